@@ sv/mbrf_pkg.sv @@
// Shared types, codes and the CRC-16/MODBUS byte update for the Modbus RTU
// request framer. No dependencies.
`default_nettype none

package mbrf_pkg;

  // Default store sizes and limits
  localparam int unsigned COIL_DEPTH_DEF     = 128;
  localparam int unsigned REG_DEPTH_DEF      = 1024;
  localparam int unsigned MAX_WRITE_REGS_DEF = 27;
  localparam int unsigned MAX_COIL_BYTES     = 54;

  // Input word kinds
  localparam logic [1:0] KIND_LOAD_COIL = 2'd0;
  localparam logic [1:0] KIND_LOAD_REG  = 2'd1;
  localparam logic [1:0] KIND_COMMAND   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_BYTE        = 2'd0;
  localparam logic [1:0] STAT_UNSUPPORTED = 2'd1;
  localparam logic [1:0] STAT_RANGE       = 2'd2;
  localparam logic [1:0] STAT_NOT_SENT    = 2'd3;

  // Modbus function codes handled by the framer
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] COIL_ON_WORD = 16'hFF00;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] start_addr;
    logic [15:0] value_or_length;
    logic [9:0]  store_index;
    logic [15:0] store_value;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic [1:0] status;
  } out_t;

  // Fold one byte into a reflected CRC-16/MODBUS accumulator
  function automatic logic [15:0] mbrf_crc_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/modbus_request_framer_core.sv @@
// Modbus RTU request framer top level: coil and register stores, frame
// sequencer and shared CRC unit. Depends on mbrf_pkg.
//
// Usage: the input channel takes words of three kinds. A coil load or a
// register load writes one store entry if its index is in range and gives no result.
// A command word builds a complete RTU request frame that leaves the output
// channel one byte per word, CRC low byte then high byte last, with last set
// on the final byte. A bad command gives a single error word instead.
// After a command is taken, the sequencer passes the check state and then
// loads the first byte of the frame into the output register from the header
// state. Header, byte count and register data bytes follow one per cycle while
// the output is not stalled; each full coil byte of function 15 is gathered bit
// by bit and then packed, since the coil store has one read port that returns
// one bit per cycle. A frame of function 16 with 27 registers has 63 bytes.
// The input is stalled from the cycle after a command is taken until its final
// word is loaded into the output register.
// Reset: both stores are swept to zero, one entry per cycle, until the deeper
// store is fully cleared; the input stays stalled meanwhile.
// A stalled output holds its word; the sequencer waits until it is taken.
`default_nettype none

module modbus_request_framer_core
  import mbrf_pkg::*;
#(
  parameter int unsigned COIL_DEPTH     = COIL_DEPTH_DEF,
  parameter int unsigned REG_DEPTH      = REG_DEPTH_DEF,
  parameter int unsigned MAX_WRITE_REGS = MAX_WRITE_REGS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned CAW       = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
  localparam int unsigned RAW       = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
  localparam int unsigned MAX_DEPTH = (COIL_DEPTH > REG_DEPTH) ? COIL_DEPTH : REG_DEPTH;
  localparam logic [16:0] COIL_LIM  = 17'(COIL_DEPTH);
  localparam logic [16:0] REG_LIM   = 17'(REG_DEPTH);
  localparam logic [16:0] CLR_END   = 17'(MAX_DEPTH - 1);
  localparam logic [15:0] WREG_LIM  = 16'(MAX_WRITE_REGS);
  localparam logic [15:0] WCOIL_LIM = 16'(8 * MAX_COIL_BYTES);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_HEAD   = 4'd3;
  localparam logic [3:0] ST_COUNT  = 4'd4;
  localparam logic [3:0] ST_DATA   = 4'd5;
  localparam logic [3:0] ST_GATHER = 4'd6;
  localparam logic [3:0] ST_PACK   = 4'd7;
  localparam logic [3:0] ST_CRC_LO = 4'd8;
  localparam logic [3:0] ST_CRC_HI = 4'd9;
  localparam logic [3:0] ST_ERR    = 4'd10;

  // Control registers
  logic [3:0]  state_q, state_d;
  logic [16:0] clr_q, clr_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic        pend_q, pend_d;
  logic        half_q, half_d;
  logic [3:0]  bitcnt_q, bitcnt_d;
  logic [2:0]  cap_q, cap_d;
  logic [2:0]  pos_q, pos_d;

  // Command payload registers
  logic [7:0]  slave_q, slave_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] vl_q, vl_d;
  logic [16:0] ptr_q, ptr_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  acc_q, acc_d;
  logic [1:0]  status_q, status_d;
  out_t        out_q, out_d;

  // Store ports
  logic            coil_mem [COIL_DEPTH];
  logic [15:0]     reg_mem  [REG_DEPTH];
  logic            coil_we, coil_wdata, coil_re, coil_rd_q;
  logic [CAW-1:0]  coil_waddr;
  logic            reg_we, reg_re;
  logic [RAW-1:0]  reg_waddr;
  logic [15:0]     reg_wdata, reg_rd_q;

  // Sequencer helpers
  logic        out_free, emit, feed;
  out_t        emit_data;
  logic [16:0] idx_ext, end_addr;
  logic        coil_in, reg_in, is_wr_coils, is_wr_regs;
  logic [7:0]  wr_lo, wr_hi;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign idx_ext     = {7'd0, in_data_i.store_index};
  assign end_addr    = ptr_q + {1'b0, vl_q};
  assign coil_in     = (ptr_q < COIL_LIM);
  assign reg_in      = (ptr_q < REG_LIM);
  assign is_wr_coils = (func_q == FC_WRITE_COILS);
  assign is_wr_regs  = (func_q == FC_WRITE_REGS);

  // Select the value word of a single write, or the count of a read or multi-write
  always_comb begin
    if (func_q == FC_WRITE_COIL) begin
      wr_hi = coil_rd_q ? COIL_ON_WORD[15:8] : 8'h00;
      wr_lo = coil_rd_q ? COIL_ON_WORD[7:0] : 8'h00;
    end else if (func_q == FC_WRITE_REG) begin
      wr_hi = reg_rd_q[15:8];
      wr_lo = reg_rd_q[7:0];
    end else begin
      wr_hi = vl_q[15:8];
      wr_lo = vl_q[7:0];
    end
  end

  // Sequence clear, loads and frames, at most one output word per step
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    half_d      = half_q;
    bitcnt_d    = bitcnt_q;
    cap_d       = cap_q;
    pos_d       = pos_q;
    slave_d     = slave_q;
    func_d      = func_q;
    vl_d        = vl_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    status_d    = status_q;
    out_d       = out_q;
    emit        = 1'b0;
    feed        = 1'b0;
    emit_data   = '0;
    coil_we     = 1'b0;
    coil_waddr  = ptr_q[CAW-1:0];
    coil_wdata  = 1'b0;
    coil_re     = 1'b0;
    reg_we      = 1'b0;
    reg_waddr   = ptr_q[RAW-1:0];
    reg_wdata   = 16'h0000;
    reg_re      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        coil_we    = (clr_q < COIL_LIM);
        coil_waddr = clr_q[CAW-1:0];
        reg_we     = (clr_q < REG_LIM);
        reg_waddr  = clr_q[RAW-1:0];
        clr_d      = clr_q + 17'd1;
        if (clr_q == CLR_END) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_LOAD_COIL: begin
              coil_we    = (idx_ext < COIL_LIM);
              coil_waddr = idx_ext[CAW-1:0];
              coil_wdata = (in_data_i.store_value != 16'h0000);
            end
            KIND_LOAD_REG: begin
              reg_we    = (idx_ext < REG_LIM);
              reg_waddr = idx_ext[RAW-1:0];
              reg_wdata = in_data_i.store_value;
            end
            KIND_COMMAND: begin
              slave_d = in_data_i.slave_addr;
              func_d  = in_data_i.function_code;
              vl_d    = in_data_i.value_or_length;
              ptr_d   = {1'b0, in_data_i.start_addr};
              crc_d   = CRC_INIT;
              state_d = ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        pos_d   = 3'd0;
        cnt_d   = vl_q;
        state_d = ST_HEAD;
        unique case (func_q) inside
          FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING: begin
          end
          FC_WRITE_COIL: begin
            if (vl_q != 16'd1) begin
              status_d = STAT_NOT_SENT;
              state_d  = ST_ERR;
            end else if (!coil_in) begin
              status_d = STAT_RANGE;
              state_d  = ST_ERR;
            end else begin
              coil_re = 1'b1;
            end
          end
          FC_WRITE_REG: begin
            if (vl_q != 16'd1) begin
              status_d = STAT_NOT_SENT;
              state_d  = ST_ERR;
            end else if (!reg_in) begin
              status_d = STAT_RANGE;
              state_d  = ST_ERR;
            end else begin
              reg_re = 1'b1;
            end
          end
          FC_WRITE_COILS: begin
            if (vl_q == 16'd0 || vl_q > WCOIL_LIM || end_addr > COIL_LIM) begin
              status_d = STAT_RANGE;
              state_d  = ST_ERR;
            end
          end
          FC_WRITE_REGS: begin
            if (vl_q == 16'd0 || vl_q > WREG_LIM || end_addr > REG_LIM) begin
              status_d = STAT_RANGE;
              state_d  = ST_ERR;
            end
          end
          default: begin
            status_d = STAT_UNSUPPORTED;
            state_d  = ST_ERR;
          end
        endcase
      end
      ST_HEAD: begin
        case (pos_q)
          3'd0:    emit_data.frame_byte = slave_q;
          3'd1:    emit_data.frame_byte = func_q;
          3'd2:    emit_data.frame_byte = ptr_q[15:8];
          3'd3:    emit_data.frame_byte = ptr_q[7:0];
          3'd4:    emit_data.frame_byte = wr_hi;
          3'd5:    emit_data.frame_byte = wr_lo;
          default: emit_data.frame_byte = 8'h00;
        endcase
        if (out_free) begin
          emit  = 1'b1;
          feed  = 1'b1;
          pos_d = pos_q + 3'd1;
          if (pos_q == 3'd5) begin
            state_d = (is_wr_coils || is_wr_regs) ? ST_COUNT : ST_CRC_LO;
          end
        end
      end
      ST_COUNT: begin
        // byte count: coils round up to whole bytes, registers take two each
        emit_data.frame_byte = is_wr_coils ? 8'(({1'b0, vl_q} + 17'd7) >> 3)
                                           : 8'({vl_q, 1'b0});
        reg_re = is_wr_regs;
        if (out_free) begin
          emit = 1'b1;
          feed = 1'b1;
          if (is_wr_regs) begin
            ptr_d   = ptr_q + 17'd1;
            half_d  = 1'b0;
            state_d = ST_DATA;
          end else begin
            bitcnt_d = 4'd0;
            cap_d    = 3'd0;
            acc_d    = 8'h00;
            pend_d   = 1'b0;
            state_d  = ST_GATHER;
          end
        end
      end
      ST_DATA: begin
        emit_data.frame_byte = half_q ? reg_rd_q[7:0] : reg_rd_q[15:8];
        if (out_free) begin
          emit   = 1'b1;
          feed   = 1'b1;
          half_d = !half_q;
          if (half_q) begin
            cnt_d = cnt_q - 16'd1;
            if (cnt_q == 16'd1) begin
              state_d = ST_CRC_LO;
            end else begin
              // fetch the next register while its high byte is due next
              reg_re = 1'b1;
              ptr_d  = ptr_q + 17'd1;
            end
          end
        end
      end
      ST_GATHER: begin
        // shift in the coil read last cycle, issue the next one
        if (pend_q) begin
          acc_d[cap_q] = coil_rd_q;
          cap_d        = cap_q + 3'd1;
        end
        if (bitcnt_q != 4'd8 && cnt_q != 16'd0) begin
          coil_re  = 1'b1;
          ptr_d    = ptr_q + 17'd1;
          cnt_d    = cnt_q - 16'd1;
          bitcnt_d = bitcnt_q + 4'd1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_PACK;
          end
        end
      end
      ST_PACK: begin
        emit_data.frame_byte = acc_q;
        if (out_free) begin
          emit = 1'b1;
          feed = 1'b1;
          if (cnt_q == 16'd0) begin
            state_d = ST_CRC_LO;
          end else begin
            acc_d    = 8'h00;
            bitcnt_d = 4'd0;
            cap_d    = 3'd0;
            state_d  = ST_GATHER;
          end
        end
      end
      ST_CRC_LO: begin
        emit_data.frame_byte = crc_q[7:0];
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        emit_data.frame_byte = crc_q[15:8];
        emit_data.last       = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        emit_data.last   = 1'b1;
        emit_data.status = status_q;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load the output register, or drop a word once it is taken
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
      if (feed) begin
        crc_d = mbrf_crc_byte(crc_q, emit_data.frame_byte);
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      half_q      <= 1'b0;
      bitcnt_q    <= '0;
      cap_q       <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      half_q      <= half_d;
      bitcnt_q    <= bitcnt_d;
      cap_q       <= cap_d;
      pos_q       <= pos_d;
    end
  end

  // Command and output payload
  always_ff @(posedge clk_i) begin
    slave_q  <= slave_d;
    func_q   <= func_d;
    vl_q     <= vl_d;
    ptr_q    <= ptr_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // Coil store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (coil_we) begin
      coil_mem[coil_waddr] <= coil_wdata;
    end
    if (coil_re) begin
      coil_rd_q <= coil_mem[ptr_q[CAW-1:0]];
    end
  end

  // Holding-register store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
    if (reg_re) begin
      reg_rd_q <= reg_mem[ptr_q[RAW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ sv/mbrf_checker.sv @@
// Port-level checks for the Modbus RTU request framer, bound to
// modbus_request_framer_core. Depends on mbrf_pkg.
`default_nettype none

module mbrf_checker
  import mbrf_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // An error word is a zero byte that closes the frame
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_BYTE |->
      out_data_o.last && out_data_o.frame_byte == 8'h00)
    else $error("error word with data or without last");

  // A taken command blocks the input until its frame is done
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind == KIND_COMMAND |=> in_stall_o)
    else $error("input open right after a command");

  // Mid-frame bytes are pending only while the input is blocked
  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input open with a frame unfinished");

endmodule

bind modbus_request_framer_core mbrf_checker u_mbrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ tb/sv/modbus_request_framer_core_tb.sv @@
// Self-checking testbench for modbus_request_framer_core: directed corner cases
// and random traffic, checked byte for byte against a built-in frame predictor.
// Depends on mbrf_pkg and the modbus_request_framer_core RTL.
`timescale 1ns / 1ps

module modbus_request_framer_core_tb;
  import mbrf_pkg::*;

  localparam int unsigned COIL_N       = COIL_DEPTH_DEF;
  localparam int unsigned REG_N        = REG_DEPTH_DEF;
  localparam int unsigned WRITE_REGS_N = MAX_WRITE_REGS_DEF;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_REPORTS  = 100;

  // Word kind and function codes that the package leaves unnamed
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [7:0] FC_READ_INPUT = 8'd4;
  localparam logic [7:0] FC_ZERO       = 8'h00;
  localparam logic [7:0] FC_TOP        = 8'hFF;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Predictor state: images of both stores and the queue of pending bytes
  logic        coil_img [COIL_N];
  logic [15:0] reg_img  [REG_N];
  out_t        frame_q  [$];

  bit          quiet_mode = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned frames_predicted = 0;
  int unsigned errors_predicted = 0;
  int unsigned bytes_checked = 0;

  modbus_request_framer_core #(
    .COIL_DEPTH    (COIL_N),
    .REG_DEPTH     (REG_N),
    .MAX_WRITE_REGS(WRITE_REGS_N)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
               frame_q.size());
      $display("modbus_request_framer_core verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Reflected CRC-16, one data bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                               input logic [7:0]  data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ data[i]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Queue the frame body followed by its CRC, low byte first
  function automatic void push_frame(input logic [7:0] body[$]);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      frame_q.push_back('{frame_byte: body[i], last: 1'b0, status: STAT_BYTE});
      crc = crc16_update(crc, body[i]);
    end
    frame_q.push_back('{frame_byte: crc[7:0], last: 1'b0, status: STAT_BYTE});
    frame_q.push_back('{frame_byte: crc[15:8], last: 1'b1, status: STAT_BYTE});
    frames_predicted++;
  endfunction

  function automatic void push_error(input logic [1:0] code);
    frame_q.push_back('{frame_byte: 8'h00, last: 1'b1, status: code});
    errors_predicted++;
  endfunction

  // Update the store images or queue the bytes that one word causes
  function automatic void predict_request(input in_t w);
    logic [7:0]  body[$];
    logic [7:0]  packed_byte;
    logic [15:0] data_word;
    int unsigned start, count, nbytes, j, m;
    start = w.start_addr;
    count = w.value_or_length;
    case (w.kind)
      KIND_LOAD_COIL: begin
        if (w.store_index < COIL_N) coil_img[w.store_index] = (w.store_value != 16'h0000);
      end
      KIND_LOAD_REG: begin
        if (w.store_index < REG_N) reg_img[w.store_index] = w.store_value;
      end
      KIND_COMMAND: begin
        body.push_back(w.slave_addr);
        body.push_back(w.function_code);
        body.push_back(w.start_addr[15:8]);
        body.push_back(w.start_addr[7:0]);
        body.push_back(w.value_or_length[15:8]);
        body.push_back(w.value_or_length[7:0]);
        case (w.function_code)
          FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING: push_frame(body);
          FC_WRITE_COIL: begin
            // The send enable is checked before the address
            if (count != 1) push_error(STAT_NOT_SENT);
            else if (start >= COIL_N) push_error(STAT_RANGE);
            else begin
              data_word = coil_img[start] ? COIL_ON_WORD : 16'h0000;
              body[4] = data_word[15:8];
              body[5] = data_word[7:0];
              push_frame(body);
            end
          end
          FC_WRITE_REG: begin
            if (count != 1) push_error(STAT_NOT_SENT);
            else if (start >= REG_N) push_error(STAT_RANGE);
            else begin
              data_word = reg_img[start];
              body[4] = data_word[15:8];
              body[5] = data_word[7:0];
              push_frame(body);
            end
          end
          FC_WRITE_COILS: begin
            if (count == 0 || count > 8 * MAX_COIL_BYTES || start + count > COIL_N) begin
              push_error(STAT_RANGE);
            end else begin
              // Pack coils LSB first, eight per byte
              nbytes = (count + 7) / 8;
              body.push_back(8'(nbytes));
              for (j = 0; j < nbytes; j++) begin
                packed_byte = 8'h00;
                for (m = 0; m < 8; m++) begin
                  if (j * 8 + m < count && coil_img[start + j * 8 + m]) packed_byte[m] = 1'b1;
                end
                body.push_back(packed_byte);
              end
              push_frame(body);
            end
          end
          FC_WRITE_REGS: begin
            if (count == 0 || count > WRITE_REGS_N || start + count > REG_N) begin
              push_error(STAT_RANGE);
            end else begin
              body.push_back(8'(2 * count));
              for (j = 0; j < count; j++) begin
                body.push_back(reg_img[start + j][15:8]);
                body.push_back(reg_img[start + j][7:0]);
              end
              push_frame(body);
            end
          end
          default: push_error(STAT_UNSUPPORTED);
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic in_t make_cmd(input logic [7:0] slave, input logic [7:0] fc,
                                   input logic [15:0] start, input logic [15:0] count);
    in_t w;
    w.kind            = KIND_COMMAND;
    w.slave_addr      = slave;
    w.function_code   = fc;
    w.start_addr      = start;
    w.value_or_length = count;
    w.store_index     = 10'($urandom);
    w.store_value     = 16'($urandom);
    return w;
  endfunction

  function automatic in_t make_load(input logic [1:0] kind, input logic [9:0] idx,
                                    input logic [15:0] value);
    in_t w;
    w             = make_cmd(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    w.kind        = kind;
    w.store_index = idx;
    w.store_value = value;
    return w;
  endfunction

  // Offer one word after a random gap outside quiet mode; called and returns at a falling edge
  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    predict_request(w);
    words_sent++;
  endtask

  // Hold off the input until every pending byte has come out
  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Store loads at the index extremes, an out-of-range coil and a reserved kind
  task automatic test_store_loads();
    send_word(make_load(KIND_LOAD_COIL, 10'd0, 16'h8000));
    send_word(make_load(KIND_LOAD_COIL, 10'(COIL_N - 1), 16'h0001));
    send_word(make_load(KIND_LOAD_COIL, 10'h3FF, 16'hFFFF));
    send_word(make_load(KIND_LOAD_REG, 10'd0, 16'hFFFF));
    send_word(make_load(KIND_LOAD_REG, 10'd1, 16'hA55A));
    send_word(make_load(KIND_LOAD_REG, 10'h3FF, 16'h1234));
    send_word(make_load(KIND_RESERVED, 10'h155, 16'h5555));
  endtask

  // Reads send start and count unchecked
  task automatic test_read_frames();
    send_word(make_cmd(8'h00, FC_READ_COILS, 16'h0000, 16'h0000));
    send_word(make_cmd(8'h5A, FC_READ_DISCRETE, 16'h1234, 16'h00FF));
    send_word(make_cmd(8'hFF, FC_READ_HOLDING, 16'hFFFF, 16'hFFFF));
  endtask

  // Single coil and register writes: enable, range and the store values
  task automatic test_single_writes();
    send_word(make_cmd(8'h01, FC_WRITE_COIL, 16'd0, 16'd1));
    send_word(make_cmd(8'h02, FC_WRITE_COIL, 16'(COIL_N - 1), 16'd1));
    send_word(make_cmd(8'h03, FC_WRITE_COIL, 16'd0, 16'd0));
    send_word(make_cmd(8'h04, FC_WRITE_COIL, 16'hFFFF, 16'hFFFF));
    send_word(make_cmd(8'h05, FC_WRITE_COIL, 16'(COIL_N), 16'd1));
    send_word(make_cmd(8'h06, FC_WRITE_REG, 16'(REG_N - 1), 16'd1));
    send_word(make_cmd(8'h07, FC_WRITE_REG, 16'd0, 16'd2));
    send_word(make_cmd(8'h08, FC_WRITE_REG, 16'(REG_N), 16'd1));
  endtask

  // Multiple writes: full span, zero count, overrun and oversize counts
  task automatic test_multi_writes();
    send_word(make_cmd(8'h11, FC_WRITE_COILS, 16'd0, 16'(COIL_N)));
    send_word(make_cmd(8'h12, FC_WRITE_COILS, 16'd0, 16'd0));
    send_word(make_cmd(8'h13, FC_WRITE_COILS, 16'd1, 16'(COIL_N)));
    send_word(make_cmd(8'h14, FC_WRITE_COILS, 16'd0, 16'hFFFF));
    send_word(make_cmd(8'h15, FC_WRITE_REGS, 16'd0, 16'(WRITE_REGS_N)));
    send_word(make_cmd(8'h16, FC_WRITE_REGS, 16'd0, 16'(WRITE_REGS_N + 1)));
    send_word(make_cmd(8'h17, FC_WRITE_REGS, 16'(REG_N - WRITE_REGS_N), 16'(WRITE_REGS_N)));
    send_word(make_cmd(8'h18, FC_WRITE_REGS, 16'(REG_N - WRITE_REGS_N + 1),
                       16'(WRITE_REGS_N)));
    send_word(make_cmd(8'h19, FC_WRITE_REGS, 16'd0, 16'd0));
  endtask

  // Unsupported functions, the skipped read-input code among them
  task automatic test_bad_functions();
    send_word(make_cmd(8'h21, FC_READ_INPUT, 16'd0, 16'd1));
    send_word(make_cmd(8'h22, FC_ZERO, 16'd0, 16'd1));
    send_word(make_cmd(8'h23, FC_TOP, 16'hFFFF, 16'hFFFF));
  endtask

  // Mostly well-formed loads and commands, some broken ones and noise
  task automatic test_random_traffic();
    in_t         w;
    int unsigned pick, start, count, taken;
    bit          paused;
    taken  = 0;
    paused = 1'b0;
    while (taken < RANDOM_ITEMS) begin
      quiet_mode = ((taken / 25) % 4) == 3;
      if (!paused && taken >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                            : $urandom_range(0, COIL_N - 1);
        w = make_load(KIND_LOAD_COIL, 10'(start),
                      $urandom_range(0, 1) ? 16'($urandom) : 16'h0000);
      end else if (pick < 50) begin
        start = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63)
                                           : $urandom_range(0, REG_N - 1);
        w = make_load(KIND_LOAD_REG, 10'(start), 16'($urandom));
      end else if (pick < 58) begin
        w = make_cmd(8'($urandom), FC_READ_COILS + 8'($urandom_range(0, 2)),
                     16'($urandom), 16'($urandom));
      end else if (pick < 66) begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : 1;
        start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, COIL_N - 1);
        w = make_cmd(8'($urandom), FC_WRITE_COIL, 16'(start), 16'(count));
      end else if (pick < 74) begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : 1;
        case ($urandom_range(0, 7))
          0:       start = $urandom_range(0, 65535);
          1, 2:    start = $urandom_range(0, REG_N - 1);
          default: start = $urandom_range(0, 63);
        endcase
        w = make_cmd(8'($urandom), FC_WRITE_REG, 16'(start), 16'(count));
      end else if (pick < 85) begin
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, COIL_N)
                                            : $urandom_range(1, 16);
        start = $urandom_range(0, COIL_N - count);
        if ($urandom_range(0, 9) == 0) begin
          start = $urandom_range(0, COIL_N);
          count = $urandom_range(0, 2 * COIL_N);
        end
        w = make_cmd(8'($urandom), FC_WRITE_COILS, 16'(start), 16'(count));
      end else if (pick < 94) begin
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, WRITE_REGS_N)
                                            : $urandom_range(1, 6);
        start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, REG_N - count)
                                            : $urandom_range(0, 64 - count);
        if ($urandom_range(0, 9) == 0) begin
          count = $urandom_range(0, WRITE_REGS_N + 8);
          start = $urandom_range(0, 1) ? $urandom_range(REG_N - 40, REG_N + 8)
                                       : $urandom_range(0, 65535);
        end
        w = make_cmd(8'($urandom), FC_WRITE_REGS, 16'(start), 16'(count));
      end else if (pick < 98) begin
        w = make_cmd(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        w      = make_cmd(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        w.kind = KIND_RESERVED;
      end
      send_word(w);
      // Words the block drops do not count
      if (!(w.kind == KIND_RESERVED || (w.kind == KIND_LOAD_COIL && w.store_index >= COIL_N)))
        taken++;
    end
    quiet_mode = 1'b0;
  endtask

  // Output side: random stall before each word outside quiet mode, then take it
  initial begin : byte_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = quiet_mode ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Compare each taken word with the oldest pending byte
  always @(posedge clk_i) begin : byte_checker
    out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      bytes_checked++;
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte=%02h last=%0b status=%0d",
                                  out_data_o.frame_byte, out_data_o.last, out_data_o.status));
      end else begin
        want = frame_q.pop_front();
        if (out_data_o.frame_byte !== want.frame_byte)
          report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                    out_data_o.frame_byte, want.frame_byte));
        if (out_data_o.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_data_o.last, want.last));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
      end
    end
  end

  initial begin : main
    foreach (coil_img[i]) coil_img[i] = 1'b0;
    foreach (reg_img[i]) reg_img[i] = 16'h0000;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_store_loads();
    test_read_frames();
    test_single_writes();
    wait_for_results();
    test_multi_writes();
    test_bad_functions();
    wait_for_results();
    test_random_traffic();
    wait_for_results();

    $display("Covered %0d input words: %0d frames and %0d error words, %0d output bytes checked.",
             words_sent, frames_predicted, errors_predicted, bytes_checked);
    $display("Directed corners of all seven functions, then random traffic; %0d cycles.",
             cycle_count);
    if (mismatch_count == 0) begin
      $display("modbus_request_framer_core verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("modbus_request_framer_core verification failed");
    end
    $finish;
  end

endmodule
